// ----- design/buffered_sliding_frame_parser_core_defines.svh -----
// Assertion macros used by the checker of the frame parser.
`ifndef BUFFERED_SLIDING_FRAME_PARSER_CORE_DEFINES_SVH
`define BUFFERED_SLIDING_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BSFP_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BSFP_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- design/bsfp_pkg.sv -----
// Types and constants shared by the frame parser modules.
`default_nettype none

package bsfp_pkg;

  // Result status codes.
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_PENDING = 3'd3;
  localparam logic [2:0] ST_FRAME   = 3'd4;

  // Frame layout: 55 AA axis lo hi spare FA.
  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] AXIS_LOW    = 8'h00;
  localparam logic [7:0] AXIS_HIGH   = 8'hFF;
  localparam logic [7:0] SYNC_LAST   = 8'hFA;

  localparam int WIN_LEN = 7;
  // Only the first six bytes are held; the seventh is checked as it arrives.
  localparam int WIN_HELD = WIN_LEN - 1;
  localparam int WIN_FILL_W = 3;
  localparam int WIN_IDX_W = $clog2(WIN_HELD);

  // Queue between the front and the back; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic       is_byte;
    logic [2:0] status;
    logic [7:0] data;
  } bsfp_entry_t;

endpackage

`default_nettype wire

// ----- design/bsfp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/bsfp_front.sv -----
// Front end: accepts words, keeps the byte FIFO and classifies each word.
`default_nettype none

module bsfp_front #(
  parameter int FIFO_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic                  mode,
  input  wire logic [7:0]            rx_byte,
  output logic                       q_push,
  output bsfp_pkg::bsfp_entry_t      q_entry,
  input  wire logic                  q_full
);

  import bsfp_pkg::*;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr;
  logic [FILL_W-1:0] fill;
  logic              s2_valid;
  logic              s2_is_byte;
  logic [2:0]        s2_status;
  logic [7:0]        ram_rdata;

  logic accept;
  logic fifo_full;
  logic fifo_empty;
  logic do_write;
  logic do_read;

  // The RAM read stage holds its word while the queue is full.
  assign item_stall = s2_valid && q_full;
  assign accept     = item_valid && !item_stall;
  assign fifo_full  = (fill == FILL_W'(FIFO_DEPTH));
  assign fifo_empty = (fill == '0);
  assign do_write   = accept && !mode && !fifo_full;
  assign do_read    = accept && mode && !fifo_empty;

  assign q_push          = s2_valid && !q_full;
  assign q_entry.is_byte = s2_is_byte;
  assign q_entry.status  = s2_status;
  assign q_entry.data    = ram_rdata;

  bsfp_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_ptr),
    .wdata (rx_byte),
    .re    (do_read),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      fill     <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (do_write) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
        fill   <= fill + FILL_W'(1);
      end
      if (do_read) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
        fill   <= fill - FILL_W'(1);
      end
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (q_push) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_is_byte <= do_read;
      if (!mode) begin
        s2_status <= fifo_full ? ST_FULL : ST_STORED;
      end else begin
        s2_status <= fifo_empty ? ST_EMPTY : ST_PENDING;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/bsfp_queue.sv -----
// Short queue of classified words between the front and the back.
`default_nettype none

module bsfp_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire bsfp_pkg::bsfp_entry_t push_entry,
  output logic                       full,
  output logic                       valid,
  output bsfp_pkg::bsfp_entry_t      head,
  input  wire logic                  pop
);

  import bsfp_pkg::*;

  bsfp_entry_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- design/bsfp_back.sv -----
// Back end: runs the frame window on popped bytes and registers each result.
`default_nettype none

module bsfp_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire bsfp_pkg::bsfp_entry_t q_head,
  output logic                       q_pop,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [2:0]                 status,
  output logic [7:0]                 axis_code,
  output logic [7:0]                 low_byte,
  output logic [7:0]                 high_byte,
  output logic [7:0]                 spare_byte
);

  import bsfp_pkg::*;

  logic [7:0]            win      [WIN_HELD];
  logic [7:0]            win_next [WIN_HELD];
  logic [WIN_FILL_W-1:0] fill;
  logic [WIN_FILL_W-1:0] fill_next;
  logic [2:0]            status_next;
  logic [7:0]            axis_next;
  logic [7:0]            low_next;
  logic [7:0]            high_next;
  logic [7:0]            spare_next;
  logic                  frame_match;

  // The output register frees up when its word is taken.
  assign q_pop = q_valid && (!result_valid || !result_stall);

  assign frame_match = (win[0] == SYNC_FIRST) && (win[1] == SYNC_SECOND) &&
                       ((win[2] == AXIS_LOW) || (win[2] == AXIS_HIGH)) &&
                       (q_head.data == SYNC_LAST);

  always_comb begin
    win_next    = win;
    fill_next   = fill;
    status_next = q_head.status;
    axis_next   = '0;
    low_next    = '0;
    high_next   = '0;
    spare_next  = '0;
    if (q_head.is_byte) begin
      status_next = ST_PENDING;
      if (fill == WIN_FILL_W'(WIN_HELD)) begin
        if (frame_match) begin
          status_next = ST_FRAME;
          axis_next   = win[2];
          low_next    = win[3];
          high_next   = win[4];
          spare_next  = win[5];
          fill_next   = '0;
        end else begin
          // No frame: drop the oldest byte and keep six.
          for (int i = 0; i < WIN_HELD - 1; i++) begin
            win_next[i] = win[i + 1];
          end
          win_next[WIN_HELD - 1] = q_head.data;
        end
      end else begin
        win_next[fill[WIN_IDX_W-1:0]] = q_head.data;
        fill_next = fill + WIN_FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        fill         <= fill_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      win        <= win_next;
      status     <= status_next;
      axis_code  <= axis_next;
      low_byte   <= low_next;
      high_byte  <= high_next;
      spare_byte <= spare_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/buffered_sliding_frame_parser_core.sv -----
// A word accepted passes the front register, a queue slot and the output register
// on its way to the outputs, and waits there while the output stalls.
// Throughput: one word per cycle, push or poll; the FIFO RAM has separate write and
// read ports and every stage advances each cycle while the output is taken.
// Reset (rst, synchronous, active high) empties the FIFO, the queue and the
// window at once; no clearing pass is needed and words are taken right after.
`default_nettype none

module buffered_sliding_frame_parser_core #(
  parameter int FIFO_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic       mode,
  input  wire logic [7:0] rx_byte,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [2:0]      status,
  output logic [7:0]      axis_code,
  output logic [7:0]      low_byte,
  output logic [7:0]      high_byte,
  output logic [7:0]      spare_byte
);

  import bsfp_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  bsfp_entry_t q_in;
  bsfp_entry_t q_head;

  bsfp_front #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .rx_byte    (rx_byte),
    .q_push     (q_push),
    .q_entry    (q_in),
    .q_full     (q_full)
  );

  bsfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  bsfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .axis_code    (axis_code),
    .low_byte     (low_byte),
    .high_byte    (high_byte),
    .spare_byte   (spare_byte)
  );

endmodule

`default_nettype wire

// ----- design/bsfp_checker.sv -----
// Port-level checker for the frame parser, bound to the top level.
`default_nettype none
`include "buffered_sliding_frame_parser_core_defines.svh"

module bsfp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_stall,
  input wire logic       mode,
  input wire logic [7:0] rx_byte,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [2:0] status,
  input wire logic [7:0] axis_code,
  input wire logic [7:0] low_byte,
  input wire logic [7:0] high_byte,
  input wire logic [7:0] spare_byte
);

  import bsfp_pkg::*;

  // Only a found frame carries payload bytes.
  `BSFP_ASSERT_NOW(a_zero_payload, result_valid && (status != ST_FRAME), (axis_code == 8'h00) && (low_byte == 8'h00) && (high_byte == 8'h00) && (spare_byte == 8'h00), "payload not zero without a frame")

  // A found frame always has a legal axis byte.
  `BSFP_ASSERT_NOW(a_axis_legal, result_valid && (status == ST_FRAME), (axis_code == AXIS_LOW) || (axis_code == AXIS_HIGH), "frame reported with an illegal axis byte")

  // A stalled result word keeps its status, axis code and low byte.
  `BSFP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(status) && $stable(axis_code) && $stable(low_byte), "stalled result word changed")

  // A stalled input word stays put.
  `BSFP_ASSERT_NEXT(a_input_hold, item_valid && item_stall, item_valid && $stable(mode) && $stable(rx_byte), "stalled input word changed")

endmodule

bind buffered_sliding_frame_parser_core bsfp_checker u_bsfp_checker (.*);

`default_nettype wire

// ----- tb/buffered_sliding_frame_parser_core_tb.sv -----
// Testbench for the frame parser core: pushes and polls bytes and checks each status word.
module buffered_sliding_frame_parser_core_tb;
  import bsfp_pkg::*;

  localparam int FIFO_DEPTH = 256;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_WORDS = 80;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] axis_code;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic [7:0] spare_byte;
  } parse_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       mode = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] axis_code;
  logic [7:0] low_byte;
  logic [7:0] high_byte;
  logic [7:0] spare_byte;

  // Predicted state of the byte queue and the frame window.
  logic [7:0]  model_fifo [FIFO_DEPTH];
  int unsigned model_rd = 0;
  int unsigned model_wr = 0;
  int unsigned model_fill = 0;
  logic [7:0]  model_win [WIN_LEN];
  int unsigned model_win_fill = 0;

  parse_result_t expected_results[$];
  int unsigned   error_count = 0;
  int unsigned   words_sent = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   rx_hold = 0;
  bit            tx_no_idle = 1'b0;
  bit            rx_no_idle = 1'b0;

  buffered_sliding_frame_parser_core #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .mode        (mode),
    .rx_byte     (rx_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status      (status),
    .axis_code   (axis_code),
    .low_byte    (low_byte),
    .high_byte   (high_byte),
    .spare_byte  (spare_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic parse_result_t parse_word(input logic word_mode,
                                               input logic [7:0] word_byte);
    parse_result_t r;
    logic [7:0]    popped;
    int            i;
    r = '0;
    if (!word_mode) begin
      if (model_fill >= FIFO_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        model_fifo[model_wr] = word_byte;
        model_wr = (model_wr + 1) % FIFO_DEPTH;
        model_fill++;
        r.status = ST_STORED;
      end
    end else if (model_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      popped = model_fifo[model_rd];
      model_rd = (model_rd + 1) % FIFO_DEPTH;
      model_fill--;
      model_win[model_win_fill] = popped;
      model_win_fill++;
      r.status = ST_PENDING;
      if (model_win_fill == WIN_LEN) begin
        if (model_win[0] == SYNC_FIRST && model_win[1] == SYNC_SECOND &&
            (model_win[2] == AXIS_LOW || model_win[2] == AXIS_HIGH) &&
            model_win[6] == SYNC_LAST) begin
          r.status = ST_FRAME;
          r.axis_code = model_win[2];
          r.low_byte = model_win[3];
          r.high_byte = model_win[4];
          r.spare_byte = model_win[5];
          model_win_fill = 0;
        end else begin
          // No frame here: drop the oldest byte and keep looking.
          for (i = 0; i < WIN_LEN - 1; i++) model_win[i] = model_win[i + 1];
          model_win_fill = WIN_LEN - 1;
        end
      end
    end
    return r;
  endfunction

  // Appends one frame; a broken one has a bad sync byte or a bad axis code.
  function automatic void build_frame(ref byte_q_t q, input bit broken);
    logic [7:0] f [WIN_LEN];
    int         pos;
    f[0] = SYNC_FIRST;
    f[1] = SYNC_SECOND;
    f[2] = $urandom_range(0, 1) ? AXIS_HIGH : AXIS_LOW;
    f[3] = 8'($urandom_range(0, 255));
    f[4] = 8'($urandom_range(0, 255));
    f[5] = 8'($urandom_range(0, 255));
    f[6] = SYNC_LAST;
    if (broken) begin
      case ($urandom_range(0, 3))
        0: pos = 0;
        1: pos = 1;
        2: pos = 2;
        default: pos = 6;
      endcase
      if (pos == 2) begin
        f[2] = $urandom_range(0, 1) ? 8'($urandom_range(1, 254)) :
               ($urandom_range(0, 1) ? 8'h01 : 8'hFE);
      end else begin
        f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
      end
    end
    foreach (f[i]) q.push_back(f[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    error_count++;
    if (error_count <= 40) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  task automatic send_word(input logic word_mode, input logic [7:0] word_byte);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    mode <= word_mode;
    rx_byte <= word_byte;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected_results.push_back(parse_word(word_mode, word_byte));
    words_sent++;
  endtask

  task automatic poll_word;
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_results;
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_poll_empty;
    send_word(1'b1, 8'hFF);
    send_word(1'b1, 8'h00);
  endtask

  // A stray byte ahead of the frame forces one slide before the match.
  task automatic test_frame_search;
    byte_q_t bytes;
    bytes = '{8'h12, SYNC_FIRST, SYNC_SECOND, AXIS_HIGH, 8'h00, 8'hFF, 8'h7E, SYNC_LAST};
    foreach (bytes[i]) send_word(1'b0, bytes[i]);
    repeat (bytes.size()) poll_word();
  endtask

  task automatic test_fifo_full;
    byte_q_t fill;
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b0;
    while (fill.size() + WIN_LEN <= FIFO_DEPTH) build_frame(fill, $urandom_range(0, 5) == 0);
    while (fill.size() < FIFO_DEPTH + 3) fill.push_back(8'($urandom_range(0, 255)));
    foreach (fill[i]) send_word(1'b0, fill[i]);
    tx_no_idle = 1'b0;
    repeat (FIFO_DEPTH + 2) poll_word();
  endtask

  task automatic test_random_traffic;
    byte_q_t     burst;
    int unsigned polls_owed;
    int unsigned stop_at;
    int unsigned k;
    bit          paused;
    stop_at = words_sent + RANDOM_WORDS;
    paused = 1'b0;
    while (words_sent < stop_at) begin
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = tx_no_idle ? 1'b1 : ($urandom_range(0, 3) == 0);
      burst.delete();
      k = $urandom_range(0, 19);
      if (k < 13) begin
        repeat ($urandom_range(0, 2)) burst.push_back(8'($urandom_range(0, 255)));
        build_frame(burst, 1'b0);
      end else if (k < 16) begin
        build_frame(burst, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
      end
      polls_owed = burst.size() + ($urandom_range(0, 3) == 0);
      while (burst.size() != 0 || polls_owed != 0) begin
        if (burst.size() != 0 && (polls_owed == 0 || $urandom_range(0, 1))) begin
          send_word(1'b0, burst.pop_front());
        end else begin
          poll_word();
          polls_owed--;
        end
      end
      if (!paused && words_sent >= stop_at - RANDOM_WORDS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
  endtask

  // Each accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {status, axis_code, low_byte, high_byte, spare_byte};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word, status", 8'h00, 8'(got.status));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", 8'(want.status), 8'(got.status));
        if (got.axis_code !== want.axis_code) report_mismatch("axis_code", want.axis_code, got.axis_code);
        if (got.low_byte !== want.low_byte) report_mismatch("low_byte", want.low_byte, got.low_byte);
        if (got.high_byte !== want.high_byte) report_mismatch("high_byte", want.high_byte, got.high_byte);
        if (got.spare_byte !== want.spare_byte) begin
          report_mismatch("spare_byte", want.spare_byte, got.spare_byte);
        end
      end
      rx_hold = rx_no_idle ? 0 : $urandom_range(0, 7);
    end
  end

  always @(negedge clk) begin
    if (rx_hold != 0) begin
      result_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_poll_empty();
    test_frame_search();
    wait_for_results();
    test_fifo_full();
    wait_for_results();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
